>>> rtl/text_cell_glyph_renderer_assert.svh
// assertion macros used by the checker file of the text cell glyph renderer
`ifndef TEXT_CELL_GLYPH_RENDERER_ASSERT_SVH
`define TEXT_CELL_GLYPH_RENDERER_ASSERT_SVH

// consequent checked at the same edge as the antecedent
`define TCGR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked at the edge after the antecedent
`define TCGR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/tcgr_pkg.sv
// shared constants, types and helpers of the text cell glyph renderer
`default_nettype none

package tcgr_pkg;
	localparam int DEF_COLUMNS = 40;
	localparam int DEF_LINES = 25;
	localparam int CELL_ADDR_W = 11;
	localparam int BAND_W = 5;
	localparam int FBCOL_W = 9;
	localparam int COL_LO_W = FBCOL_W - 3;
	localparam int FONT_DEPTH = 2048;
	localparam int FONT_AW = 11;
	localparam logic [7:0] GLYPH_MASK = 8'h7f;
	localparam logic [7:0] HIGH_BIT = 8'h80;

	typedef enum logic {
		OP_SCREEN = 1'b0,
		OP_FONT = 1'b1
	} opcode_t;

	// one changed cell handed to the glyph fetch unit
	typedef struct packed {
		logic [7:0] glyph;
		logic inv;
		logic [BAND_W-1:0] band;
		logic [COL_LO_W-1:0] col_lo;
	} job_t;

	typedef struct packed {
		logic en;
		logic [FONT_AW-1:0] addr;
		logic [7:0] data;
	} font_wr_t;

	typedef struct packed {
		logic job_ready;
		logic fetch_busy;
	} rend_stat_t;

	function automatic logic [7:0] glyph_of(logic [7:0] code, logic upper);
		return (code & GLYPH_MASK) | (upper ? HIGH_BIT : 8'h00);
	endfunction
endpackage

`default_nettype wire

>>> rtl/tcgr_if.sv
// valid/ready channel interfaces for input items and framebuffer results
`default_nettype none

interface tcgr_item_if
	import tcgr_pkg::*;
();
	logic valid;
	logic ready;
	opcode_t opcode;
	logic [CELL_ADDR_W-1:0] cell_address;
	logic [7:0] char_code;
	logic [7:0] glyph_index;
	logic [2:0] glyph_row;
	logic [7:0] glyph_bits;

	modport source (
		output valid, opcode, cell_address, char_code, glyph_index, glyph_row, glyph_bits,
		input ready
	);
	modport sink (
		input valid, opcode, cell_address, char_code, glyph_index, glyph_row, glyph_bits,
		output ready
	);
endinterface

interface tcgr_result_if
	import tcgr_pkg::*;
();
	logic valid;
	logic ready;
	logic [BAND_W-1:0] fb_band;
	logic [FBCOL_W-1:0] fb_column;
	logic [7:0] fb_byte;
	logic last;

	modport source (
		output valid, fb_band, fb_column, fb_byte, last,
		input ready
	);
	modport sink (
		input valid, fb_band, fb_column, fb_byte, last,
		output ready
	);
endinterface

`default_nettype wire

>>> rtl/tcgr_cell_render.sv
// font store, row fetch, transpose into column bytes and output buffer
`default_nettype none

module tcgr_cell_render
	import tcgr_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input font_wr_t font_wr,
	input logic job_valid,
	input job_t job,
	output rend_stat_t stat,
	tcgr_result_if.source result
);
	logic [7:0] font_mem [FONT_DEPTH];

	// fetch side
	logic fetch_valid_q;
	job_t job_q;
	logic [2:0] row_q;
	logic issue;
	logic job_take;

	// read data stage
	logic rd_valid_s2;
	logic [2:0] rd_row_s2;
	job_t rd_job_s2;
	logic [7:0] font_rd_s2;
	logic [7:0] row_bits;

	// accumulator and output buffer
	logic [7:0] acc_q [8];
	logic [7:0] acc_next [8];
	job_t acc_job_q;
	logic acc_hold_q;
	logic row7_in;
	logic out_free;
	logic move;
	logic acc_busy_next;
	logic out_valid_q;
	logic [2:0] out_k_q;
	logic [7:0] out_cols_q [8];
	job_t out_job_q;
	logic out_fire;

	assign out_fire = out_valid_q && result.ready;
	assign row7_in = rd_valid_s2 && (rd_row_s2 == 3'd7);
	assign out_free = !out_valid_q || (result.ready && (out_k_q == 3'd7));
	assign move = (acc_hold_q || row7_in) && out_free;
	assign acc_busy_next = (acc_hold_q || row7_in) && !move;
	assign issue = fetch_valid_q && !acc_busy_next;
	assign job_take = job_valid && stat.job_ready;

	assign stat.job_ready = !fetch_valid_q || (issue && (row_q == 3'd7));
	assign stat.fetch_busy = fetch_valid_q;

	assign row_bits = font_rd_s2 ^ {8{rd_job_s2.inv}};

	// row r of the glyph lands in bit 7-r of every column byte
	always_comb begin
		for (int k = 0; k < 8; k++) begin
			acc_next[k] = (rd_row_s2 == 3'd0) ? 8'h00 : acc_q[k];
			acc_next[k][3'd7 - rd_row_s2] = row_bits[3'd7 - 3'(k)];
		end
	end

	always_ff @(posedge clk) begin
		if (font_wr.en) begin
			font_mem[font_wr.addr] <= font_wr.data;
		end
		if (issue) begin
			font_rd_s2 <= font_mem[{job_q.glyph, row_q}];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fetch_valid_q <= 1'b0;
			row_q <= 3'd0;
			rd_valid_s2 <= 1'b0;
			acc_hold_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_k_q <= 3'd0;
		end else begin
			rd_valid_s2 <= issue;
			acc_hold_q <= acc_busy_next;
			if (job_take) begin
				fetch_valid_q <= 1'b1;
				row_q <= 3'd0;
			end else if (issue) begin
				if (row_q == 3'd7) begin
					fetch_valid_q <= 1'b0;
				end
				row_q <= row_q + 3'd1;
			end
			if (move) begin
				out_valid_q <= 1'b1;
				out_k_q <= 3'd0;
			end else if (out_fire) begin
				if (out_k_q == 3'd7) begin
					out_valid_q <= 1'b0;
				end
				out_k_q <= out_k_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_take) begin
			job_q <= job;
		end
		if (issue) begin
			rd_row_s2 <= row_q;
			rd_job_s2 <= job_q;
		end
		if (rd_valid_s2) begin
			acc_q <= acc_next;
			acc_job_q <= rd_job_s2;
		end
		if (move) begin
			if (row7_in) begin
				out_cols_q <= acc_next;
			end else begin
				out_cols_q <= acc_q;
			end
			out_job_q <= row7_in ? rd_job_s2 : acc_job_q;
		end
	end

	assign result.valid = out_valid_q;
	assign result.fb_band = out_job_q.band;
	assign result.fb_column = {out_job_q.col_lo, out_k_q};
	assign result.fb_byte = out_cols_q[out_k_q];
	assign result.last = (out_k_q == 3'd7);
endmodule

`default_nettype wire

>>> rtl/text_cell_glyph_renderer.sv
// Text cell glyph renderer top level. Items arrive on the item channel: a font load writes
// one 8-bit row of the 256-glyph font store, a screen write names a cell and a character
// code. A screen write to a cell off the screen, or with the code the cell already holds,
// gives no result; otherwise the code is stored and eight framebuffer bytes leave on the
// result channel, one vertical pixel column each, left to right, the eighth with last set.
// The glyph is the code's low 7 bits with bit 7 taken from upper_set; code bit 7 inverts
// the pixels. The font store gives one glyph row a cycle while the accumulator is free,
// the result channel moves one byte a cycle while ready is high, and both overlap across
// cells. Font loads, unchanged cells and off-screen cells start no row fetch, but a font
// load waits until the row fetches of every earlier cell are issued. After reset the
// screen store is swept to zero, one cell a cycle, over all COLUMNS*LINES cells (1000 by
// default) before the first item is accepted; upper_set may be written at any time the
// block is idle.
`default_nettype none

module text_cell_glyph_renderer
	import tcgr_pkg::*;
#(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int LINES = DEF_LINES
) (
	input logic clk,
	input logic arst_n,
	tcgr_item_if.sink item,
	tcgr_result_if.source result,
	input logic cfg_we,
	input logic cfg_wdata
);
	localparam int CELLS = COLUMNS * LINES;
	localparam int CELL_AW = (CELLS > 1) ? $clog2(CELLS) : 1;
	// band = address / COLUMNS as a multiply by a rounded-up reciprocal; the shift is wide
	// enough that the error never reaches the next integer for any address on the port
	localparam int DIV_SHIFT = 20;
	localparam int DIV_RECIP = ((1 << DIV_SHIFT) + COLUMNS - 1) / COLUMNS;
	localparam int PROD_W = CELL_ADDR_W + DIV_SHIFT + 1;

	// configuration
	logic upper_set_q;

	// screen store and its clearing sweep
	logic [7:0] scr_mem [CELLS];
	logic clr_busy_q;
	logic [CELL_AW-1:0] clr_idx_q;
	logic scr_we;
	logic [CELL_AW-1:0] scr_waddr;
	logic [7:0] scr_wdata;

	// input decode
	logic item_fire;
	logic is_font;
	logic in_range;
	logic item_scr;
	logic [CELL_AW-1:0] item_idx;
	logic [PROD_W-1:0] div_prod;

	// compare stage: stored code arrives from the screen store
	logic valid_s1;
	logic [CELL_AW-1:0] addr_s1;
	logic [7:0] code_s1;
	logic [BAND_W-1:0] band_s1;
	logic [7:0] scr_rd_s1;
	logic fwd_hit_s1;
	logic [7:0] fwd_code_s1;
	logic [7:0] stored_code;
	logic changed;
	logic s1_adv;
	logic cell_wr;
	logic [CELL_ADDR_W-1:0] band_mul;
	logic [CELL_ADDR_W-1:0] col_rem;

	// glyph unit hookup
	font_wr_t font_wr;
	job_t job;
	logic job_valid;
	rend_stat_t rstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_set_q <= 1'b0;
		end else if (cfg_we) begin
			upper_set_q <= cfg_wdata;
		end
	end

	// reset sweep writes zero into every cell, one a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_idx_q == CELL_AW'(CELLS - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	assign is_font = (item.opcode == OP_FONT);
	assign in_range = (item.cell_address < CELL_ADDR_W'(CELLS));
	assign item_idx = item.cell_address[CELL_AW-1:0];

	// a font load must not overtake the row fetches of an earlier cell
	assign item.ready = !clr_busy_q
		&& (is_font ? (!valid_s1 && !rstat.fetch_busy) : (!valid_s1 || s1_adv));
	assign item_fire = item.valid && item.ready;
	assign item_scr = item_fire && !is_font && in_range;

	assign div_prod = PROD_W'(item.cell_address) * PROD_W'(DIV_RECIP);

	// the cell written back this cycle is the one a following item may read at the same
	// edge, so its code is carried along instead of the stale store output
	assign stored_code = fwd_hit_s1 ? fwd_code_s1 : scr_rd_s1;
	assign changed = (stored_code != code_s1);
	assign cell_wr = valid_s1 && changed && rstat.job_ready;
	assign s1_adv = valid_s1 && (!changed || rstat.job_ready);

	assign scr_we = clr_busy_q || cell_wr;
	assign scr_waddr = clr_busy_q ? clr_idx_q : addr_s1;
	assign scr_wdata = clr_busy_q ? 8'h00 : code_s1;

	always_ff @(posedge clk) begin
		if (scr_we) begin
			scr_mem[scr_waddr] <= scr_wdata;
		end
		if (item_scr) begin
			scr_rd_s1 <= scr_mem[item_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_scr) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_scr) begin
			addr_s1 <= item_idx;
			code_s1 <= item.char_code;
			band_s1 <= div_prod[DIV_SHIFT +: BAND_W];
			fwd_hit_s1 <= cell_wr && (addr_s1 == item_idx);
			fwd_code_s1 <= code_s1;
		end
	end

	// column within the line from the registered band, then the changed cell's job
	assign band_mul = CELL_ADDR_W'(32'(band_s1) * COLUMNS);
	assign col_rem = CELL_ADDR_W'(addr_s1) - band_mul;

	assign job_valid = valid_s1 && changed;
	assign job.glyph = glyph_of(code_s1, upper_set_q);
	assign job.inv = code_s1[7];
	assign job.band = band_s1;
	assign job.col_lo = col_rem[COL_LO_W-1:0];

	assign font_wr.en = item_fire && is_font;
	assign font_wr.addr = {item.glyph_index, item.glyph_row};
	assign font_wr.data = item.glyph_bits;

	tcgr_cell_render u_render (
		.clk(clk),
		.arst_n(arst_n),
		.font_wr(font_wr),
		.job_valid(job_valid),
		.job(job),
		.stat(rstat),
		.result(result)
	);
endmodule

`default_nettype wire

>>> rtl/tcgr_checker.sv
// port-level checks of the text cell glyph renderer, bound to its top level
`default_nettype none

`include "text_cell_glyph_renderer_assert.svh"

module tcgr_checker
	import tcgr_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic item_ready,
	input logic result_valid,
	input logic result_ready,
	input logic [BAND_W-1:0] fb_band,
	input logic [FBCOL_W-1:0] fb_column,
	input logic [7:0] fb_byte,
	input logic last
);
	logic res_fire;

	assign res_fire = result_valid && result_ready;

	// the eighth column of a cell carries the last marker, and only it
	`TCGR_ASSERT_SAME(a_last_col, clk, arst_n, result_valid, last == (fb_column[2:0] == 3'd7), "last marker out of step with column")
	// the eight bytes of a cell follow one another with no gap
	`TCGR_ASSERT_NEXT(a_cell_cont, clk, arst_n, res_fire && !last, result_valid && fb_band == $past(fb_band) && fb_column == $past(fb_column) + 9'd1, "cell bytes broken up")
	// a result held back keeps its byte
	`TCGR_ASSERT_NEXT(a_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(fb_byte), "stalled result changed")
	// screen sweep runs right after reset, so nothing is taken yet
	`TCGR_ASSERT_SAME(a_sweep, clk, arst_n, !$past(arst_n), !item_ready, "item taken during screen sweep")
endmodule

bind text_cell_glyph_renderer tcgr_checker u_tcgr_checker (
	.clk(clk),
	.arst_n(arst_n),
	.item_ready(item.ready),
	.result_valid(result.valid),
	.result_ready(result.ready),
	.fb_band(result.fb_band),
	.fb_column(result.fb_column),
	.fb_byte(result.fb_byte),
	.last(result.last)
);

`default_nettype wire
